### rtl/vms_pkg.sv
// Shared types and constants for the von Mises strain block.
package vms_pkg;

    // Field widths and fixed-point format
    localparam int IN_WIDTH  = 16;
    localparam int FRAC_BITS = 12;
    localparam int TAG_W     = 16;
    localparam int OUT_W     = 16;

    // Internal widths: column dot products, magnitudes, squares, weighted sum
    localparam int PROD_W = 2 * IN_WIDTH;
    localparam int DOT_W  = PROD_W + 2;
    localparam int MAG_W  = PROD_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int PSUM_W = SQ_W + 2;
    localparam int SUM_W  = SQ_W + 4;

    // S / (12 * 2^(2q)) = (S >> (2q+2)) / 3
    localparam int T_SHIFT = 2 * FRAC_BITS + 2;
    localparam int T_W     = 2 * OUT_W + 2;

    // Root of 2^(2*OUT_W) or above saturates: S >= 3 * 2^(T_SHIFT + 2*OUT_W)
    localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'(3) << (T_SHIFT + 2 * OUT_W);

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // Square-root pipeline: one stage per result bit
    localparam int SQRT_STAGES = OUT_W;
    localparam int TRIAL_W     = T_W + 2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [TAG_W-1:0]           particle_tag;
        logic signed [IN_WIDTH-1:0] f_00;
        logic signed [IN_WIDTH-1:0] f_01;
        logic signed [IN_WIDTH-1:0] f_02;
        logic signed [IN_WIDTH-1:0] f_10;
        logic signed [IN_WIDTH-1:0] f_11;
        logic signed [IN_WIDTH-1:0] f_12;
        logic signed [IN_WIDTH-1:0] f_20;
        logic signed [IN_WIDTH-1:0] f_21;
        logic signed [IN_WIDTH-1:0] f_22;
    } in_word_t;

    typedef struct packed {
        logic [TAG_W-1:0] result_tag;
        logic [OUT_W-1:0] equivalent_strain;
        logic             saturated;
    } out_word_t;

    // Classified word handed from front to back
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             sat;
        logic [T_W-1:0]   t_val;
    } mid_word_t;

endpackage

### rtl/vms_front.sv
// Front end: accept gradients, form the weighted strain sum and classify saturation.
module vms_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  vms_pkg::in_word_t  item,
    output logic               mid_push,
    input  logic               mid_full,
    output vms_pkg::mid_word_t mid_word
);
    import vms_pkg::*;

    localparam int N_STG = 6;
    localparam int N_DOT = 6;
    localparam int N_PROD = 3 * N_DOT;
    // Column pairs of C = F^T F: diagonal terms first, then off-diagonal
    localparam int PAIR_I [N_DOT] = '{0, 1, 2, 0, 0, 1};
    localparam int PAIR_J [N_DOT] = '{0, 1, 2, 1, 2, 2};

    logic                     adv;
    logic [N_STG-1:0]         valid_reg;
    logic [N_STG-1:0]         valid_next;
    logic signed [IN_WIDTH-1:0] fm [3][3];

    logic [TAG_W-1:0]         tag_reg [N_STG-1];

    logic signed [PROD_W-1:0] prod_reg  [N_PROD];
    logic signed [PROD_W-1:0] prod_next [N_PROD];
    logic signed [DOT_W-1:0]  dot_reg   [N_DOT];
    logic signed [DOT_W-1:0]  dot_next  [N_DOT];
    logic [MAG_W-1:0]         mag_reg   [N_DOT];
    logic [MAG_W-1:0]         mag_next  [N_DOT];
    logic [SQ_W-1:0]          sq_reg    [N_DOT];
    logic [SQ_W-1:0]          sq_next   [N_DOT];
    logic [PSUM_W-1:0]        sum_d_reg;
    logic [PSUM_W-1:0]        sum_d_next;
    logic [PSUM_W-1:0]        sum_o_reg;
    logic [PSUM_W-1:0]        sum_o_next;
    mid_word_t                mid_reg;
    mid_word_t                mid_next;
    logic [SUM_W-1:0]         s_total;

    // Advance unless the last stage holds a word the queue cannot take
    assign adv      = !(valid_reg[N_STG-1] && mid_full);
    assign full     = !adv;
    assign mid_push = valid_reg[N_STG-1] && !mid_full;
    assign mid_word = mid_reg;

    assign valid_next = {valid_reg[N_STG-2:0], push};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // Shift the tag along with the data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg[0] <= item.particle_tag;
            for (int s = 1; s < N_STG - 1; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    // Stage 1: the eighteen column products
    always_comb
    begin
        fm[0][0] = item.f_00; fm[0][1] = item.f_01; fm[0][2] = item.f_02;
        fm[1][0] = item.f_10; fm[1][1] = item.f_11; fm[1][2] = item.f_12;
        fm[2][0] = item.f_20; fm[2][1] = item.f_21; fm[2][2] = item.f_22;
        for (int p = 0; p < N_DOT; p++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[3*p+k] = PROD_W'(fm[k][PAIR_I[p]] * fm[k][PAIR_J[p]]);
            end
        end
    end

    // Stage 2: dot products C_ij
    always_comb
    begin
        for (int p = 0; p < N_DOT; p++)
        begin
            dot_next[p] = DOT_W'(prod_reg[3*p]) + DOT_W'(prod_reg[3*p+1])
                        + DOT_W'(prod_reg[3*p+2]);
        end
    end

    // Stage 3: magnitudes of diagonal differences and off-diagonal terms
    always_comb
    begin
        logic signed [DOT_W-1:0] val [N_DOT];
        val[0] = dot_reg[0] - dot_reg[1];
        val[1] = dot_reg[1] - dot_reg[2];
        val[2] = dot_reg[2] - dot_reg[0];
        val[3] = dot_reg[3];
        val[4] = dot_reg[4];
        val[5] = dot_reg[5];
        for (int p = 0; p < N_DOT; p++)
        begin
            mag_next[p] = val[p][DOT_W-1] ? MAG_W'(-val[p]) : MAG_W'(val[p]);
        end
    end

    // Stage 4: squares
    always_comb
    begin
        for (int p = 0; p < N_DOT; p++)
        begin
            sq_next[p] = SQ_W'(mag_reg[p]) * SQ_W'(mag_reg[p]);
        end
    end

    // Stage 5: partial sums
    assign sum_d_next = PSUM_W'(sq_reg[0]) + PSUM_W'(sq_reg[1]) + PSUM_W'(sq_reg[2]);
    assign sum_o_next = PSUM_W'(sq_reg[3]) + PSUM_W'(sq_reg[4]) + PSUM_W'(sq_reg[5]);

    // Stage 6: weight the off-diagonal sum by six, classify saturation
    always_comb
    begin
        s_total = SUM_W'(sum_d_reg) + (SUM_W'(sum_o_reg) << 2) + (SUM_W'(sum_o_reg) << 1);
        mid_next.tag   = tag_reg[N_STG-2];
        mid_next.sat   = (s_total >= SAT_LIMIT);
        mid_next.t_val = s_total[T_SHIFT +: T_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= prod_next;
            dot_reg   <= dot_next;
            mag_reg   <= mag_next;
            sq_reg    <= sq_next;
            sum_d_reg <= sum_d_next;
            sum_o_reg <= sum_o_next;
            mid_reg   <= mid_next;
        end
    end

endmodule

### rtl/vms_queue.sv
// Short queue that decouples the front end from the square-root back end.
module vms_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  vms_pkg::mid_word_t din,
    input  logic               pop,
    output logic               empty,
    output vms_pkg::mid_word_t dout
);
    import vms_pkg::*;

    mid_word_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store the word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

### rtl/vms_back.sv
// Back end: pipelined bit-per-stage square root of the scaled sum.
module vms_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mid_empty,
    output logic               mid_pop,
    input  vms_pkg::mid_word_t mid_word,
    output logic               empty,
    input  logic               pop,
    output vms_pkg::out_word_t result
);
    import vms_pkg::*;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             sat;
        logic [T_W-1:0]   rem;
        logic [OUT_W-1:0] root;
    } sq_stage_t;

    logic                   adv;
    logic [SQRT_STAGES-1:0] valid_reg;
    logic [SQRT_STAGES-1:0] valid_next;
    sq_stage_t              stg_reg  [SQRT_STAGES];
    sq_stage_t              stg_next [SQRT_STAGES];
    sq_stage_t              stg_in   [SQRT_STAGES];
    sq_stage_t              last;

    // Freeze everything while the finished word waits
    assign adv     = !valid_reg[SQRT_STAGES-1] || pop;
    assign mid_pop = adv && !mid_empty;
    assign empty   = !valid_reg[SQRT_STAGES-1];

    assign valid_next = {valid_reg[SQRT_STAGES-2:0], !mid_empty};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage inputs: the queue head, then the previous stage
    always_comb
    begin
        stg_in[0].tag  = mid_word.tag;
        stg_in[0].sat  = mid_word.sat;
        stg_in[0].rem  = mid_word.t_val;
        stg_in[0].root = '0;
        for (int j = 1; j < SQRT_STAGES; j++)
        begin
            stg_in[j] = stg_reg[j-1];
        end
    end

    // Decide one root bit per stage: keep it when 3*(2^(k+1) r + 4^k) fits the remainder
    always_comb
    begin
        logic [TRIAL_W-1:0] trial;
        logic [TRIAL_W-1:0] trial3;
        int                 k;
        for (int j = 0; j < SQRT_STAGES; j++)
        begin
            k = SQRT_STAGES - 1 - j;
            trial  = (TRIAL_W'(stg_in[j].root) << (k + 1)) + (TRIAL_W'(1) << (2 * k));
            trial3 = trial + (trial << 1);
            stg_next[j] = stg_in[j];
            if (TRIAL_W'(stg_in[j].rem) >= trial3)
            begin
                stg_next[j].rem  = stg_in[j].rem - trial3[T_W-1:0];
                stg_next[j].root = stg_in[j].root | (OUT_W'(1) << k);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stg_reg <= stg_next;
        end
    end

    // Drive the result word from the last stage
    assign last = stg_reg[SQRT_STAGES-1];
    assign result.result_tag        = last.tag;
    assign result.equivalent_strain = last.sat ? OUT_MAX : last.root;
    assign result.saturated         = last.sat;

endmodule

### rtl/von_mises_strain_from_deformation.sv
// Top level of the von Mises equivalent strain block.
//
//  channel   | handshake    | word         | accepted when
//  ----------+--------------+--------------+------------------------
//  input     | push / full  | item         | push && !full
//  result    | empty / pop  | result       | pop && !empty
//
// One word per cycle enters and leaves while neither side stalls; a word passes 23
// register stages: six front stages (products, sums, magnitudes, squares, partial
// sums, weighting), one queue write and sixteen square-root stages, one result bit
// each. Reset clears all valid bits, the queue pointers and the queue occupancy;
// the data registers and the queue storage are not reset.
// While a result waits unpopped the root pipeline freezes, the four-word queue
// keeps absorbing the front end, and full rises once the queue is full and the
// last front stage holds a word.
module von_mises_strain_from_deformation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  vms_pkg::in_word_t  item,
    output logic               empty,
    input  logic               pop,
    output vms_pkg::out_word_t result
);
    import vms_pkg::*;

    logic      mid_push;
    logic      mid_full;
    logic      mid_pop;
    logic      mid_empty;
    mid_word_t front_word;
    mid_word_t queue_word;

    vms_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .mid_push (mid_push),
        .mid_full (mid_full),
        .mid_word (front_word)
    );

    vms_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .full  (mid_full),
        .din   (front_word),
        .pop   (mid_pop),
        .empty (mid_empty),
        .dout  (queue_word)
    );

    vms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .mid_word  (queue_word),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // No result is offered in the cycle after reset is seen
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result offered after reset");

    // The back end never drains an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> !mid_empty)
        else $error("queue popped while empty");

    // The front end never pushes into a full queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> !mid_full)
        else $error("queue pushed while full");

    // A saturated result carries the maximum code
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.saturated) |-> (result.equivalent_strain == OUT_MAX))
        else $error("saturated result without maximum value");

endmodule

### tb/sv/von_mises_strain_from_deformation_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the von Mises equivalent strain block.
module von_mises_strain_from_deformation_tb;
    import vms_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_WORDS = 1600;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic signed [IN_WIDTH-1:0] ONE_F   = 16'sh1000;
    localparam logic signed [IN_WIDTH-1:0] NEG_ONE = 16'shF000;
    localparam logic signed [IN_WIDTH-1:0] ZERO_F  = 16'sh0000;
    localparam logic signed [IN_WIDTH-1:0] MAX_F   = 16'sh7FFF;
    localparam logic signed [IN_WIDTH-1:0] MIN_F   = 16'sh8000;
    localparam logic [OUT_W-1:0]           ZERO_STRAIN = '0;

    typedef enum int unsigned {
        POP_ALWAYS,
        POP_COIN_FLIP,
        POP_TRICKLE,
        POP_ALTERNATE
    } pop_mode_t;

    typedef struct {
        in_word_t         word;
        bit               typed;
        logic [OUT_W-1:0] strain;
        logic             sat;
    } directed_row_t;

    localparam int N_DIRECTED = 20;

    // Directed gradients: fixed answers only where they are obvious
    directed_row_t directed_rows [N_DIRECTED] = '{
        // identity, zero, both extremes everywhere
        '{'{16'h0000, ONE_F, ZERO_F, ZERO_F, ZERO_F, ONE_F, ZERO_F, ZERO_F, ZERO_F, ONE_F},
          1'b1, ZERO_STRAIN, 1'b0},
        '{'{16'hFFFF, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F},
          1'b1, ZERO_STRAIN, 1'b0},
        '{'{16'h8001, MIN_F, MIN_F, MIN_F, MIN_F, MIN_F, MIN_F, MIN_F, MIN_F, MIN_F},
          1'b1, OUT_MAX, 1'b1},
        '{'{16'h7FFE, MAX_F, MAX_F, MAX_F, MAX_F, MAX_F, MAX_F, MAX_F, MAX_F, MAX_F},
          1'b1, OUT_MAX, 1'b1},
        // reflection and rigid rotation leave no strain
        '{'{16'h0004, NEG_ONE, ZERO_F, ZERO_F, ZERO_F, NEG_ONE, ZERO_F, ZERO_F, ZERO_F, NEG_ONE},
          1'b1, ZERO_STRAIN, 1'b0},
        '{'{16'h0005, ZERO_F, NEG_ONE, ZERO_F, ONE_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ONE_F},
          1'b1, ZERO_STRAIN, 1'b0},
        // one extreme entry alone saturates
        '{'{16'h0006, MAX_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F},
          1'b1, OUT_MAX, 1'b1},
        '{'{16'h0007, MIN_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F},
          1'b1, OUT_MAX, 1'b1},
        // stretch, compression and shear
        '{'{16'h0008, 16'sh2000, ZERO_F, ZERO_F, ZERO_F, ONE_F, ZERO_F, ZERO_F, ZERO_F, ONE_F},
          1'b0, ZERO_STRAIN, 1'b0},
        '{'{16'h0009, ONE_F, ONE_F, ZERO_F, ZERO_F, ONE_F, ZERO_F, ZERO_F, ZERO_F, ONE_F},
          1'b0, ZERO_STRAIN, 1'b0},
        '{'{16'h000A, ONE_F, ZERO_F, ZERO_F, ZERO_F, ONE_F, NEG_ONE, ZERO_F, ZERO_F, ONE_F},
          1'b0, ZERO_STRAIN, 1'b0},
        '{'{16'h000B, 16'sh0E66, ZERO_F, ZERO_F, ZERO_F, ONE_F, ZERO_F, ZERO_F, ZERO_F, ONE_F},
          1'b0, ZERO_STRAIN, 1'b0},
        // around the saturation threshold
        '{'{16'h000C, 16'sh652C, ZERO_F, ZERO_F, ZERO_F, ONE_F, ZERO_F, ZERO_F, ZERO_F, ONE_F},
          1'b0, ZERO_STRAIN, 1'b0},
        '{'{16'h000D, 16'sh6590, ZERO_F, ZERO_F, ZERO_F, ONE_F, ZERO_F, ZERO_F, ZERO_F, ONE_F},
          1'b0, ZERO_STRAIN, 1'b0},
        '{'{16'h000E, ONE_F, ZERO_F, ZERO_F, ZERO_F, ONE_F, ZERO_F, ZERO_F, ZERO_F, 16'sh9A70},
          1'b0, ZERO_STRAIN, 1'b0},
        // single LSB effects
        '{'{16'h000F, 16'sh1001, ZERO_F, ZERO_F, ZERO_F, ONE_F, ZERO_F, ZERO_F, ZERO_F, ONE_F},
          1'b0, ZERO_STRAIN, 1'b0},
        '{'{16'h0010, 16'sh0001, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F, ZERO_F},
          1'b0, ZERO_STRAIN, 1'b0},
        // mixed signs and off-diagonal extremes
        '{'{16'hA5A5, MAX_F, ZERO_F, ZERO_F, ZERO_F, MIN_F, ZERO_F, ZERO_F, ZERO_F, ONE_F},
          1'b0, ZERO_STRAIN, 1'b0},
        '{'{16'h5A5A, ZERO_F, ZERO_F, ZERO_F, MAX_F, ZERO_F, ZERO_F, MIN_F, ZERO_F, ZERO_F},
          1'b0, ZERO_STRAIN, 1'b0},
        '{'{16'h1234, ONE_F, 16'sh0001, ZERO_F, 16'shFFFF, ONE_F, 16'sh0800, ZERO_F,
            16'shF800, ONE_F},
          1'b0, ZERO_STRAIN, 1'b0}
    };

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_word_t  item;
    logic      empty;
    logic      pop;
    out_word_t result;

    // Fixed answer that travels with the word on the input side
    bit        word_typed;
    out_word_t word_typed_result;

    out_word_t   pending_strains [$];
    out_word_t   expected_word;
    bit          took_word;
    int unsigned burst_left;
    int unsigned cycle_count;
    int unsigned words_taken;
    int unsigned results_checked;
    int unsigned saturated_seen;
    int unsigned mismatches;

    von_mises_strain_from_deformation u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Exact square of a signed magnitude
    function automatic logic [127:0] mag_sq(input longint v);
        logic [63:0] m;
        m = (v < 0) ? 64'(-v) : 64'(v);
        return 128'(m) * 128'(m);
    endfunction

    // Expected equivalent strain of one gradient
    function automatic out_word_t strain_of(input in_word_t w);
        longint       g  [3][3];
        longint       cc [3][3];
        logic [127:0] s;
        logic [127:0] quot;
        logic [32:0]  rem;
        logic [32:0]  root;
        logic [32:0]  trial;
        logic [32:0]  probe;
        out_word_t    r;
        g[0][0] = w.f_00; g[0][1] = w.f_01; g[0][2] = w.f_02;
        g[1][0] = w.f_10; g[1][1] = w.f_11; g[1][2] = w.f_12;
        g[2][0] = w.f_20; g[2][1] = w.f_21; g[2][2] = w.f_22;
        // Form C = F^T F exactly
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cc[i][j] = 0;
                for (int k = 0; k < 3; k++)
                    cc[i][j] += g[k][i] * g[k][j];
            end
        end
        s = mag_sq(cc[0][0] - cc[1][1]) + mag_sq(cc[1][1] - cc[2][2])
          + mag_sq(cc[2][2] - cc[0][0])
          + 128'd6 * (mag_sq(cc[0][1]) + mag_sq(cc[0][2]) + mag_sq(cc[1][2]));
        quot = s / (128'd12 << (2 * FRAC_BITS));
        r.result_tag = w.particle_tag;
        if (quot >= (128'd1 << (2 * OUT_W)))
        begin
            r.equivalent_strain = OUT_MAX;
            r.saturated         = 1'b1;
        end
        else
        begin
            // Truncating integer square root, one result bit per pass
            rem   = 33'(quot[2*OUT_W-1:0]);
            root  = '0;
            probe = 33'd1 << (2 * OUT_W - 2);
            repeat (OUT_W)
            begin
                trial = root + probe;
                if (rem >= trial)
                begin
                    rem  = rem - trial;
                    root = (root >> 1) + probe;
                end
                else
                    root = root >> 1;
                probe = probe >> 2;
            end
            r.equivalent_strain = root[OUT_W-1:0];
            r.saturated         = 1'b0;
        end
        return r;
    endfunction

    // Signed random value in [-2^k, 2^k - 1]
    function automatic logic signed [IN_WIDTH-1:0] wobble(input int unsigned k);
        return IN_WIDTH'(int'($urandom_range(0, (2 << k) - 1)) - (1 << k));
    endfunction

    // Random gradient from a mix of shapes
    function automatic in_word_t random_gradient();
        logic signed [IN_WIDTH-1:0] g [9];
        int unsigned shape;
        int unsigned k;
        int unsigned shift;
        int unsigned axis;
        shape = $urandom_range(0, 9);
        k     = $urandom_range(2, 12);
        shift = $urandom_range(0, 2);
        axis  = $urandom_range(0, 2);
        for (int n = 0; n < 9; n++)
        begin
            if (shape < 4)
                g[n] = ((n % 4 == 0) ? ONE_F : ZERO_F) + wobble(k);
            else if (shape < 6)
                g[n] = wobble($urandom_range(8, 14));
            else if (shape < 8)
                g[n] = IN_WIDTH'($urandom);
            else if (shape == 8)
                g[n] = (n % 4 == 0) ? ONE_F : ZERO_F;
            else
                g[n] = ((n % 3) == ((n / 3 + shift) % 3))
                     ? (($urandom_range(0, 1) != 0) ? ONE_F : NEG_ONE) + wobble(2)
                     : wobble(2);
        end
        // Large stretch along one axis, near saturation
        if (shape == 8)
        begin
            g[axis * 4] = IN_WIDTH'($urandom_range(20000, 32767));
            if ($urandom_range(0, 1) != 0)
                g[axis * 4] = -g[axis * 4];
        end
        return {IN_WIDTH'($urandom), g[0], g[1], g[2], g[3], g[4], g[5], g[6], g[7], g[8]};
    endfunction

    // Offer one word in bursts with random gaps; return once it is taken
    task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                              : $urandom_range(1, 10);
        end
        burst_left--;
        if (gap != 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item              = w;
        word_typed        = typed;
        word_typed_result = typed_res;
        push              = 1'b1;
        do
            @(negedge clk);
        while (!took_word);
    endtask

    // Sample both handshakes; predict on input, check on output
    always @(posedge clk)
    begin
        cycle_count++;
        took_word = push && !full;
        if (took_word)
        begin
            words_taken++;
            if (word_typed)
                pending_strains.push_back(word_typed_result);
            else
                pending_strains.push_back(strain_of(item));
        end
        if (pop && !empty)
        begin
            if (pending_strains.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no word pending, expected none, got %h",
                         $time, result);
            end
            else
            begin
                expected_word = pending_strains.pop_front();
                results_checked++;
                if (result.saturated)
                    saturated_seen++;
                if (result.result_tag !== expected_word.result_tag)
                begin
                    mismatches++;
                    $display("%0t: result_tag mismatch, expected %h, got %h",
                             $time, expected_word.result_tag, result.result_tag);
                end
                if (result.equivalent_strain !== expected_word.equivalent_strain)
                begin
                    mismatches++;
                    $display("%0t: equivalent_strain mismatch (tag %h), expected %h, got %h",
                             $time, expected_word.result_tag,
                             expected_word.equivalent_strain, result.equivalent_strain);
                end
                if (result.saturated !== expected_word.saturated)
                begin
                    mismatches++;
                    $display("%0t: saturated mismatch (tag %h), expected %b, got %b",
                             $time, expected_word.result_tag,
                             expected_word.saturated, result.saturated);
                end
            end
        end
    end

    // Stall the result side on its own changing pattern
    initial
    begin : receiver
        pop_mode_t   mode;
        int unsigned span;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = pop_mode_t'($urandom_range(0, 3));
            span = $urandom_range(16, 200);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    POP_ALWAYS:    pop = 1'b1;
                    POP_COIN_FLIP: pop = ($urandom_range(0, 1) != 0);
                    POP_TRICKLE:   pop = ($urandom_range(0, 7) == 0);
                    default:       pop = ~pop;
                endcase
            end
        end
    end

    // Stop a hung run
    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: cycle limit reached with %0d words pending",
                 $time, pending_strains.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        out_word_t typed_res;
        rst_n             = 1'b0;
        push              = 1'b0;
        item              = '0;
        word_typed        = 1'b0;
        word_typed_result = '0;
        burst_left        = 0;
        cycle_count       = 0;
        words_taken       = 0;
        results_checked   = 0;
        saturated_seen    = 0;
        mismatches        = 0;
        took_word         = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (directed_rows[r])
        begin
            typed_res = '{directed_rows[r].word.particle_tag,
                          directed_rows[r].strain, directed_rows[r].sat};
            send_word(directed_rows[r].word, directed_rows[r].typed, typed_res);
        end

        // Random gradients
        for (int n = 0; n < RANDOM_WORDS; n++)
            send_word(random_gradient(), 1'b0, '0);
        push       = 1'b0;
        word_typed = 1'b0;

        // Drain, then allow for any stray result
        while (pending_strains.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d gradients (%0d from the directed table) under bursty input",
                 words_taken, N_DIRECTED);
        $display("and stalled output; checked %0d results, %0d of them saturated.",
                 results_checked, saturated_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
